// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the sector cache tag engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define CRST_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// clocked check, active during reset as well
`define CRST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define CRST_ASSERT(lbl, clk, rst_n, prop)
`define CRST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/crst_pkg.sv =====
// ----------------------------------------------------------------------------
// crst_pkg
// types and constants of the clock replacement sector cache tag engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crst_pkg;

  localparam int SECTOR_W    = 32;
  localparam int SLOT_W      = 6;
  localparam int FUNC_W      = 2;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SECTOR_W-1:0] sector;
  } crst_in_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fetch;
    logic                writeback;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } crst_out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH,
    OP_SWEEP,
    OP_VICT,
    OP_FSCAN,
    OP_FTAG,
    OP_FEND
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic srch_hit;
    logic srch_miss;
    logic victim_found;
    logic flush_dirty;
    logic flush_end;
  } status_t;

endpackage

// ===== rtl/core/crst_ctrl.sv =====
// ----------------------------------------------------------------------------
// crst_ctrl
// sequencer for search, clock sweep and flush of the tag engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crst_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [crst_pkg::FUNC_W-1:0]   in_func,
  output logic                          busy,
  output crst_pkg::cmd_t                cmd,
  input  crst_pkg::status_t             status
);
  import crst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SWEEP,
    ST_VICT,
    ST_FSCAN,
    ST_FTAG,
    ST_FEND
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (in_func == FUNC_READ || in_func == FUNC_WRITE) begin
            state_nxt = ST_SRCH;
          end else if (in_func == FUNC_FLUSH) begin
            state_nxt = ST_FSCAN;
          end
        end
      end
      ST_SRCH: begin
        cmd.op = OP_SRCH;
        if (status.srch_hit) begin
          state_nxt = ST_IDLE;
        end else if (status.srch_miss) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (status.victim_found) begin
          state_nxt = ST_VICT;
        end
      end
      ST_VICT: begin
        cmd.op    = OP_VICT;
        state_nxt = ST_IDLE;
      end
      ST_FSCAN: begin
        cmd.op = OP_FSCAN;
        if (status.flush_end) begin
          state_nxt = ST_FEND;
        end else if (status.flush_dirty) begin
          state_nxt = ST_FTAG;
        end
      end
      ST_FTAG: begin
        cmd.op    = OP_FTAG;
        state_nxt = ST_FSCAN;
      end
      ST_FEND: begin
        cmd.op    = OP_FEND;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/crst_dp.sv =====
// ----------------------------------------------------------------------------
// crst_dp
// tag memory, policy bits, clock hand and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crst_dp #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crst_pkg::crst_in_t  in_word,
  input  crst_pkg::cmd_t      cmd,
  output crst_pkg::status_t   status,
  output logic                out_strobe,
  output crst_pkg::crst_out_t out_word
);
  import crst_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW:0]   ENT_CNT  = (IW+1)'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [SECTOR_W-1:0] tag_mem [ENTRIES];
  logic [SECTOR_W-1:0] rd_data_r;
  logic [IW-1:0]       mem_ra;
  logic                mem_we;

  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  dirty_r, dirty_nxt;
  logic [ENTRIES-1:0]  ref_r, ref_nxt;
  logic [IW-1:0]       hand_r, hand_nxt;
  logic [IW:0]         iss_r, iss_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [IW-1:0]       pend_slot_r, pend_slot_nxt;
  logic [SECTOR_W-1:0] pend_tag_r, pend_tag_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [SECTOR_W-1:0] sector_r, sector_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  crst_out_t           out_r, out_nxt;

  logic [IW-1:0]       iss_idx;
  logic                hit_now;
  logic                vict_wb;

  assign iss_idx    = iss_r[IW-1:0];
  assign hit_now    = cmp_v_r && valid_r[cmp_idx_r] && (rd_data_r == sector_r);
  assign vict_wb    = valid_r[hand_r] && dirty_r[hand_r];
  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  // tag memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[hand_r] <= sector_r;
    end
    rd_data_r <= tag_mem[mem_ra];
  end

  always_comb begin
    valid_nxt      = valid_r;
    dirty_nxt      = dirty_r;
    ref_nxt        = ref_r;
    hand_nxt       = hand_r;
    iss_nxt        = iss_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_tag_nxt   = pend_tag_r;
    func_nxt       = func_r;
    sector_nxt     = sector_r;
    mem_ra         = hand_r;
    mem_we         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    status         = '0;
    unique case (cmd.op)
      OP_LOAD: begin
        func_nxt   = in_word.func;
        sector_nxt = in_word.sector;
        iss_nxt    = '0;
        cnt_nxt    = '0;
        pend_v_nxt = 1'b0;
      end
      OP_SRCH: begin
        // read one tag per cycle, compare it the cycle after
        if (iss_r < ENT_CNT) begin
          mem_ra      = iss_idx;
          iss_nxt     = iss_r + (IW+1)'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = iss_idx;
        end
        if (hit_now) begin
          ref_nxt[cmp_idx_r] = 1'b1;
          if (func_r == FUNC_WRITE) begin
            dirty_nxt[cmp_idx_r] = 1'b1;
          end
          out_strobe_nxt = 1'b1;
          out_nxt.hit    = 1'b1;
          out_nxt.slot   = SLOT_W'(cmp_idx_r);
          out_nxt.last   = 1'b1;
          status.srch_hit = 1'b1;
        end else if (cmp_v_r && cmp_idx_r == LAST_IDX) begin
          status.srch_miss = 1'b1;
        end
      end
      OP_SWEEP: begin
        // second chance: referenced entries lose the bit and the hand moves
        if (valid_r[hand_r] && ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt = (hand_r == LAST_IDX) ? '0 : hand_r + IW'(1);
        end else begin
          status.victim_found = 1'b1;
        end
      end
      OP_VICT: begin
        mem_we                   = 1'b1;
        valid_nxt[hand_r]        = 1'b1;
        ref_nxt[hand_r]          = 1'b1;
        dirty_nxt[hand_r]        = (func_r == FUNC_WRITE);
        out_strobe_nxt           = 1'b1;
        out_nxt.slot             = SLOT_W'(hand_r);
        out_nxt.fetch            = 1'b1;
        out_nxt.writeback        = vict_wb;
        out_nxt.writeback_sector = vict_wb ? rd_data_r : '0;
        out_nxt.last             = 1'b1;
      end
      OP_FSCAN: begin
        if (iss_r == ENT_CNT || cnt_r == CNT_W'(MAX_RESULTS)) begin
          status.flush_end = 1'b1;
        end else if (valid_r[iss_idx] && dirty_r[iss_idx]) begin
          mem_ra             = iss_idx;
          dirty_nxt[iss_idx] = 1'b0;
          status.flush_dirty = 1'b1;
        end else begin
          iss_nxt = iss_r + (IW+1)'(1);
        end
      end
      OP_FTAG: begin
        // hold one word back so the final one can carry last
        if (pend_v_r) begin
          out_strobe_nxt           = 1'b1;
          out_nxt.slot             = SLOT_W'(pend_slot_r);
          out_nxt.writeback        = 1'b1;
          out_nxt.writeback_sector = pend_tag_r;
        end
        pend_v_nxt    = 1'b1;
        pend_slot_nxt = iss_idx;
        pend_tag_nxt  = rd_data_r;
        cnt_nxt       = cnt_r + CNT_W'(1);
        iss_nxt       = iss_r + (IW+1)'(1);
      end
      OP_FEND: begin
        out_strobe_nxt = 1'b1;
        out_nxt.last   = 1'b1;
        if (pend_v_r) begin
          out_nxt.slot             = SLOT_W'(pend_slot_r);
          out_nxt.writeback        = 1'b1;
          out_nxt.writeback_sector = pend_tag_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      dirty_r      <= '0;
      ref_r        <= '0;
      hand_r       <= '0;
      iss_r        <= '0;
      cmp_v_r      <= 1'b0;
      cnt_r        <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      dirty_r      <= dirty_nxt;
      ref_r        <= ref_nxt;
      hand_r       <= hand_nxt;
      iss_r        <= iss_nxt;
      cmp_v_r      <= cmp_v_nxt;
      cnt_r        <= cnt_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_tag_r  <= pend_tag_nxt;
    func_r      <= func_nxt;
    sector_r    <= sector_nxt;
    out_r       <= out_nxt;
  end

  `CRST_ASSERT(a_hit_clean, clk, rst_n, out_strobe_r && out_r.hit |-> !out_r.fetch && !out_r.writeback)
  `CRST_ASSERT(a_fill_marks, clk, rst_n, out_strobe_r && out_r.fetch |-> valid_r[hand_r] && ref_r[hand_r])
  `CRST_ASSERT(a_flush_cap, clk, rst_n, cnt_r <= CNT_W'(MAX_RESULTS))
  `CRST_ASSERT(a_pend_set, clk, rst_n, cmd.op == OP_FTAG |=> pend_v_r)

endmodule

// ===== rtl/core/clock_replacement_sector_cache_tags_core.sv =====
// ----------------------------------------------------------------------------
// clock_replacement_sector_cache_tags_core
// fully associative sector cache tags with clock replacement and flush
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy drops in the cycle
// that the last result is on out_word. Results appear on out_word for exactly
// one cycle with out_strobe high, and the receiver cannot stall them. An
// access scans the tag memory one entry per cycle through its single read
// port: a hit ends the scan at the matching entry; a miss takes the full
// scan, then a clock sweep that moves the hand past referenced entries,
// clearing their bits, and a fill. A flush scans every entry and writes back
// each dirty one, up to MAX_RESULTS. The result strobe follows the cycle
// after each result is formed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_replacement_sector_cache_tags_core #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  crst_pkg::crst_in_t  in_word,
  output logic                out_strobe,
  output crst_pkg::crst_out_t out_word
);
  import crst_pkg::*;

  cmd_t    cmd;
  status_t status;

  crst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_word.func),
    .busy    (busy),
    .cmd     (cmd),
    .status  (status)
  );

  crst_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

// ===== tb/clock_replacement_sector_cache_tags_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_sector_cache_tags_core_test
// self-checking bench for the clock replacement sector cache tag engine
// ----------------------------------------------------------------------------
// A queue of access, flush and unused-code words is built up front and fed
// to the engine by a clocked driver with phases of random sender idling. A
// shadow copy of the tags, policy bits and clock hand works out the results
// of each word as it is taken. A clocked monitor compares every strobed
// result with the oldest one still owed. A hot pool of sectors gives hits,
// a wider pool and fully random sectors give misses, sweeps and dirty
// evictions, and a burst of ENTRIES random writes precedes a full flush.
// ----------------------------------------------------------------------------

module clock_replacement_sector_cache_tags_core_test;
  import crst_pkg::*;

  localparam int ENTRIES = 64;
  localparam int POOL = 96;
  localparam int RANDOM_WORDS = 330;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  crst_in_t in_word = '0;
  logic out_strobe;
  crst_out_t out_word;

  crst_in_t access_queue[$];
  crst_out_t owed_results[$];

  logic                tag_valid [ENTRIES];
  logic                tag_dirty [ENTRIES];
  logic                tag_ref [ENTRIES];
  logic [SECTOR_W-1:0] tag_sector [ENTRIES];
  logic [SLOT_W-1:0]   sweep_ptr;

  int words_taken = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int hit_cnt = 0;
  int evict_cnt = 0;
  int flush_cnt = 0;
  int idle_pct;

  clock_replacement_sector_cache_tags_core #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int e = 0; e < ENTRIES; e++) begin
      tag_valid[e] = 1'b0;
      tag_dirty[e] = 1'b0;
      tag_ref[e] = 1'b0;
      tag_sector[e] = '0;
    end
    sweep_ptr = '0;
  end

  task automatic track_cache(input crst_in_t w);
    crst_out_t r;
    int dirty_total;
    int n;
    int e;
    bit found;
    begin
      if (w.func == FUNC_FLUSH) begin
        flush_cnt++;
        dirty_total = 0;
        for (e = 0; e < ENTRIES; e++)
          if (tag_valid[e] && tag_dirty[e]) dirty_total++;
        if (dirty_total > MAX_RESULTS) dirty_total = MAX_RESULTS;
        if (dirty_total == 0) begin
          r = '0;
          r.last = 1'b1;
          owed_results.push_back(r);
        end else begin
          n = 0;
          for (e = 0; e < ENTRIES; e++) begin
            if (tag_valid[e] && tag_dirty[e] && n < MAX_RESULTS) begin
              r = '0;
              r.slot = e[SLOT_W-1:0];
              r.writeback = 1'b1;
              r.writeback_sector = tag_sector[e];
              r.last = (n == dirty_total - 1);
              owed_results.push_back(r);
              tag_dirty[e] = 1'b0;
              n++;
            end
          end
        end
      end else if (w.func == FUNC_READ || w.func == FUNC_WRITE) begin
        found = 1'b0;
        r = '0;
        r.last = 1'b1;
        for (e = 0; e < ENTRIES && !found; e++) begin
          if (tag_valid[e] && tag_sector[e] == w.sector) begin
            found = 1'b1;
            tag_ref[e] = 1'b1;
            if (w.func == FUNC_WRITE) tag_dirty[e] = 1'b1;
            r.hit = 1'b1;
            r.slot = e[SLOT_W-1:0];
          end
        end
        if (found) begin
          hit_cnt++;
        end else begin
          // second chance sweep
          while (tag_valid[sweep_ptr] && tag_ref[sweep_ptr]) begin
            tag_ref[sweep_ptr] = 1'b0;
            sweep_ptr = sweep_ptr + SLOT_W'(1);
          end
          r.slot = sweep_ptr;
          r.fetch = 1'b1;
          if (tag_valid[sweep_ptr] && tag_dirty[sweep_ptr]) begin
            r.writeback = 1'b1;
            r.writeback_sector = tag_sector[sweep_ptr];
            evict_cnt++;
          end
          tag_valid[sweep_ptr] = 1'b1;
          tag_sector[sweep_ptr] = w.sector;
          tag_ref[sweep_ptr] = 1'b1;
          tag_dirty[sweep_ptr] = (w.func == FUNC_WRITE);
        end
        owed_results.push_back(r);
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always_comb begin
    case ((words_taken / 48) % 4)
      1: idle_pct = 66;
      3: idle_pct = 11;
      default: idle_pct = 0;
    endcase
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        track_cache(in_word);
        words_taken++;
      end
      if (!start || !busy) begin
        if (access_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_word <= access_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    crst_out_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result word with nothing owed: slot %0d", out_word.slot);
        mismatch_cnt++;
      end else begin
        want = owed_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_word.hit));
        check_field("slot", 32'(want.slot), 32'(out_word.slot));
        check_field("fetch", 32'(want.fetch), 32'(out_word.fetch));
        check_field("writeback", 32'(want.writeback), 32'(out_word.writeback));
        check_field("writeback_sector", want.writeback_sector, out_word.writeback_sector);
        check_field("last", 32'(want.last), 32'(out_word.last));
      end
    end
  end

  task automatic add_word(input logic [FUNC_W-1:0] f, input logic [SECTOR_W-1:0] s);
    crst_in_t w;
    begin
      w.func = f;
      w.sector = s;
      access_queue.push_back(w);
    end
  endtask

  initial begin
    logic [SECTOR_W-1:0] sector_pool [POOL];
    int n;
    int pick;
    int bursts;
    logic [FUNC_W-1:0] rw;

    add_word(FUNC_FLUSH, '0);
    add_word(FUNC_READ, '0);
    add_word(FUNC_WRITE, '1);
    add_word(FUNC_READ, '1);
    add_word(FUNC_WRITE, '0);
    add_word(FUNC_UNUSED, '1);
    add_word(FUNC_READ, 32'h5555_5555);
    add_word(FUNC_WRITE, 32'hAAAA_AAAA);
    add_word(FUNC_FLUSH, 32'h1234_5678);
    add_word(FUNC_FLUSH, '0);
    add_word(FUNC_READ, '0);
    add_word(FUNC_WRITE, 32'h5555_5555);

    for (int i = 0; i < POOL; i++) sector_pool[i] = $urandom;
    n = 0;
    bursts = 0;
    while (n < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      rw = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      if (pick < 2 && bursts < 2) begin
        // write ENTRIES random sectors, then flush
        for (int k = 0; k < ENTRIES; k++) add_word(FUNC_WRITE, $urandom);
        add_word(FUNC_FLUSH, $urandom);
        n += ENTRIES + 1;
        bursts++;
      end else if (pick < 8) begin
        add_word(FUNC_FLUSH, $urandom);
        n++;
      end else if (pick < 10) begin
        add_word(FUNC_UNUSED, $urandom);
      end else if (pick < 22) begin
        add_word(rw, $urandom);
        n++;
      end else if (pick < 65) begin
        add_word(rw, sector_pool[$urandom_range(0, 31)]);
        n++;
      end else begin
        add_word(rw, sector_pool[$urandom_range(0, POOL - 1)]);
        n++;
      end
    end
    add_word(FUNC_FLUSH, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (access_queue.size() != 0 || start) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (3 * ENTRIES + 20) @(posedge clk);

    $display("tb: %0d words taken, %0d result words checked", words_taken, results_seen);
    $display("tb: %0d hits, %0d dirty evictions, %0d flushes", hit_cnt, evict_cnt, flush_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("tb: failure");
    $finish;
  end

endmodule
